FILE: sv/lru_buffer_frame_manager_macros.svh
// ----------------------------------------------------------------------------
// LRU buffer frame manager assertion macros
// Shorthand for clocked assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef LRU_BUFFER_FRAME_MANAGER_MACROS_SVH
`define LRU_BUFFER_FRAME_MANAGER_MACROS_SVH

// Same-cycle implication.
`define LBFM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LBFM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Plain invariant.
`define LBFM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

FILE: sv/lbfm_pkg.sv
// ----------------------------------------------------------------------------
// lbfm_pkg
// Shared widths, command codes and the structs passed along the frame chain.
// ----------------------------------------------------------------------------
package lbfm_pkg;

  localparam int unsigned FILE_W      = 16;
  localparam int unsigned BLOCK_W     = 32;
  localparam int unsigned FRAME_OUT_W = 4;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic               active;
    logic               found;
    logic               victim_valid;
    logic [FILE_W-1:0]  victim_file;
    logic [BLOCK_W-1:0] victim_block;
  } link_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic en;
    logic mru;
    logic lru;
    logic set_tag;
    logic clear;
  } upd_t;

endpackage

FILE: sv/lbfm_cell.sv
// ----------------------------------------------------------------------------
// lbfm_cell
// One frame: valid bit, tag and recency rank, plus one stage of the search
// chain that collects the matching frame and the least recent frame.
// ----------------------------------------------------------------------------
module lbfm_cell
  import lbfm_pkg::*;
#(
  parameter int unsigned FRAMES = 16,
  parameter int unsigned INDEX  = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [FILE_W-1:0]                         req_file_i,
  input  logic [BLOCK_W-1:0]                        req_block_i,
  input  link_t                                     link_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] match_idx_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] match_rank_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] victim_idx_i,
  output link_t                                     link_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] match_idx_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] match_rank_o,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] victim_idx_o,
  input  upd_t                                      upd_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] upd_idx_i,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] upd_rank_i,
  output logic                                      hit_o,
  output logic                                      victim_o
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IW-1:0] MyIdx    = IW'(INDEX);
  localparam logic [IW-1:0] LastRank = IW'(FRAMES - 1);

  logic               valid_q, valid_d;
  logic [IW-1:0]      rank_q, rank_d;
  logic [FILE_W-1:0]  file_q;
  logic [BLOCK_W-1:0] block_q;
  link_t              link_q, link_d;
  logic [IW-1:0]      midx_q, midx_d, mrank_q, mrank_d, vidx_q, vidx_d;
  logic               hit, take, victim, selected;

  assign hit      = valid_q && (file_q == req_file_i) && (block_q == req_block_i);
  assign victim   = (rank_q == LastRank);
  assign take     = link_i.active && hit && (!link_i.found || (rank_q < match_rank_i));
  assign selected = upd_i.en && (upd_idx_i == MyIdx);

  // Chain stage: merge own frame into the passing token.
  always_comb begin
    link_d  = link_i;
    midx_d  = match_idx_i;
    mrank_d = match_rank_i;
    vidx_d  = victim_idx_i;
    if (take) begin
      link_d.found = 1'b1;
      midx_d       = MyIdx;
      mrank_d      = rank_q;
    end
    if (link_i.active && victim) begin
      link_d.victim_valid = valid_q;
      link_d.victim_file  = file_q;
      link_d.victim_block = block_q;
      vidx_d              = MyIdx;
    end
  end

  // Rank and valid update from the broadcast.
  always_comb begin
    rank_d  = rank_q;
    valid_d = valid_q;
    if (upd_i.en) begin
      if (upd_i.mru && (rank_q < upd_rank_i)) begin
        rank_d = rank_q + 1'b1;
      end
      if (upd_i.lru && (rank_q > upd_rank_i)) begin
        rank_d = rank_q - 1'b1;
      end
    end
    if (selected) begin
      rank_d = upd_i.mru ? '0 : LastRank;
      if (upd_i.set_tag) begin
        valid_d = 1'b1;
      end
      if (upd_i.clear) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= MyIdx;
      link_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      link_q  <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    midx_q  <= midx_d;
    mrank_q <= mrank_d;
    vidx_q  <= vidx_d;
    if (selected && upd_i.set_tag) begin
      file_q  <= req_file_i;
      block_q <= req_block_i;
    end
  end

  assign link_o       = link_q;
  assign match_idx_o  = midx_q;
  assign match_rank_o = mrank_q;
  assign victim_idx_o = vidx_q;
  assign hit_o        = hit;
  assign victim_o     = victim;

endmodule

FILE: sv/lru_buffer_frame_manager.sv
// Flow: an accepted request starts a search token that walks the frame chain
// one cell per cycle; the result is loaded and the update applied once the
// result register is free, which a stalled downstream side can hold off.
// A new request is taken only after the previous result has been loaded.
// Reset: every frame empty, frame i at recency rank i, no result pending.
// ----------------------------------------------------------------------------
// lru_buffer_frame_manager
// Fully associative LRU buffer pool built as a chain of frame cells.
// ----------------------------------------------------------------------------
`include "lru_buffer_frame_manager_macros.svh"

module lru_buffer_frame_manager
  import lbfm_pkg::*;
#(
  parameter int unsigned FRAMES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request side
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // file_num[15:0], block_num[47:16]
  input  logic                  s_axis_tuser_i,  // cmd[0]
  // result side
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // hit[0], frame[4:1], write_back[5],
                                                 // old_file_num[21:6],
                                                 // old_block_num[53:22],
                                                 // removed[54], zero[55]
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IW-1:0] LastRank = IW'(FRAMES - 1);

  // Sequencer: idle, token in the chain, result/update pending.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       start_q, start_d;

  // Held request, broadcast to every cell.
  logic               cmd_q;
  logic [FILE_W-1:0]  file_q;
  logic [BLOCK_W-1:0] block_q;

  // Captured search outcome.
  link_t         res_q;
  logic [IW-1:0] res_midx_q, res_mrank_q, res_vidx_q;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic in_acc, out_free, finish;

  // Chain wiring.
  link_t         links      [FRAMES+1];
  logic [IW-1:0] midx_lnk   [FRAMES+1];
  logic [IW-1:0] mrank_lnk  [FRAMES+1];
  logic [IW-1:0] vidx_lnk   [FRAMES+1];
  logic [FRAMES-1:0] hit_vec, victim_vec;

  upd_t          upd;
  logic [IW-1:0] upd_idx, upd_rank;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign finish          = (state_q == ST_DONE) && out_free;

  // Fresh token enters cell 0 the cycle after accept.
  always_comb begin
    links[0]        = '0;
    links[0].active = start_q;
    midx_lnk[0]     = '0;
    mrank_lnk[0]    = '0;
    vidx_lnk[0]     = '0;
  end

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lbfm_cell #(
      .FRAMES (FRAMES),
      .INDEX  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .req_file_i   (file_q),
      .req_block_i  (block_q),
      .link_i       (links[i]),
      .match_idx_i  (midx_lnk[i]),
      .match_rank_i (mrank_lnk[i]),
      .victim_idx_i (vidx_lnk[i]),
      .link_o       (links[i+1]),
      .match_idx_o  (midx_lnk[i+1]),
      .match_rank_o (mrank_lnk[i+1]),
      .victim_idx_o (vidx_lnk[i+1]),
      .upd_i        (upd),
      .upd_idx_i    (upd_idx),
      .upd_rank_i   (upd_rank),
      .hit_o        (hit_vec[i]),
      .victim_o     (victim_vec[i])
    );
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SWEEP;
          start_d = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (links[FRAMES].active) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Update broadcast, applied in the cycle the result is loaded.
  always_comb begin
    upd         = '0;
    upd.en      = finish && ((cmd_q == CMD_LOOKUP) || res_q.found);
    upd.mru     = (cmd_q == CMD_LOOKUP);
    upd.lru     = (cmd_q == CMD_DELETE) && res_q.found;
    upd.set_tag = (cmd_q == CMD_LOOKUP) && !res_q.found;
    upd.clear   = (cmd_q == CMD_DELETE) && res_q.found;
    upd_idx     = upd.set_tag ? res_vidx_q : res_midx_q;
    upd_rank    = upd.set_tag ? LastRank : res_mrank_q;
  end

  // Result fields.
  logic [IW-1:0]          frame_idx;
  logic [FRAME_OUT_W-1:0] frame_out;
  logic                   r_hit, r_wb, r_removed;
  logic [FILE_W-1:0]      r_file;
  logic [BLOCK_W-1:0]     r_block;

  always_comb begin
    r_hit     = res_q.found;
    r_removed = (cmd_q == CMD_DELETE) && res_q.found;
    r_wb      = (cmd_q == CMD_LOOKUP) && !res_q.found && res_q.victim_valid;
    r_file    = r_wb ? res_q.victim_file : '0;
    r_block   = r_wb ? res_q.victim_block : '0;
    if (res_q.found) begin
      frame_idx = res_midx_q;
    end else if (cmd_q == CMD_LOOKUP) begin
      frame_idx = res_vidx_q;
    end else begin
      frame_idx = '0;
    end
  end

  // Frame field carries the low bits of the index.
  if (IW >= FRAME_OUT_W) begin : g_frame_trunc
    assign frame_out = frame_idx[FRAME_OUT_W-1:0];
  end else begin : g_frame_ext
    assign frame_out = {{(FRAME_OUT_W - IW){1'b0}}, frame_idx};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, r_removed, r_block, r_file, r_wb, frame_out, r_hit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_acc) begin
      cmd_q   <= s_axis_tuser_i;
      file_q  <= s_axis_tdata_i[FILE_W-1:0];
      block_q <= s_axis_tdata_i[FILE_W+BLOCK_W-1:FILE_W];
    end
    if ((state_q == ST_SWEEP) && links[FRAMES].active) begin
      res_q       <= links[FRAMES];
      res_midx_q  <= midx_lnk[FRAMES];
      res_mrank_q <= mrank_lnk[FRAMES];
      res_vidx_q  <= vidx_lnk[FRAMES];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Exactly one frame holds the least recent rank.
  `LBFM_ASSERT_ALWAYS(a_one_victim, $onehot(victim_vec), "rank order lost: victim not unique")
  // Valid tags stay unique, so at most one frame matches.
  `LBFM_ASSERT_ALWAYS(a_one_match, $onehot0(hit_vec), "duplicate tag in frames")
  // No new request while one is in flight.
  `LBFM_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready_o, "request taken while busy")
  // Token leaves the chain only during a sweep.
  `LBFM_ASSERT_IMP(a_token_in_sweep, links[FRAMES].active, state_q == ST_SWEEP,
                   "search token outside sweep")

endmodule

FILE: tb/lru_buffer_frame_manager_checker.sv
// ----------------------------------------------------------------------------
// lru_buffer_frame_manager_checker
// Watches both streams and keeps its own copy of the frame pool. It predicts
// each reply and compares the replies in order.
// ----------------------------------------------------------------------------
module lru_buffer_frame_manager_checker
  import lbfm_pkg::*;
#(
  parameter int unsigned FRAMES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  output int                    pending_o,
  output int                    errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // highest field first, so hit sits in bit 0
  typedef struct packed {
    logic                   removed;
    logic [BLOCK_W-1:0]     old_block;
    logic [FILE_W-1:0]      old_file;
    logic                   write_back;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   hit;
  } reply_t;

  reply_t             replies_due[$];
  logic               frame_used [FRAMES];
  logic [FILE_W-1:0]  file_tag   [FRAMES];
  logic [BLOCK_W-1:0] block_tag  [FRAMES];
  int unsigned        age        [FRAMES];  // 0 = most recent
  int                 mismatches = 0;
  int                 replies_seen = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns reply %0d: %s", $time, replies_seen, what);
    mismatches++;
  endtask

  function automatic void promote(input int idx);
    int unsigned was;
    was = age[idx];
    for (int i = 0; i < FRAMES; i++)
      if (age[i] < was) age[i]++;
    age[idx] = 0;
  endfunction

  // Apply one request to the pool copy and return the reply it must give.
  function automatic reply_t apply_request(input logic cmd, input logic [FILE_W-1:0] f,
                                           input logic [BLOCK_W-1:0] b);
    reply_t      r;
    int          match;
    int          victim;
    int unsigned was;
    r      = '0;
    match  = -1;
    victim = 0;
    // only occupied frames compare; most recent match wins
    for (int i = 0; i < FRAMES; i++)
      if (frame_used[i] && file_tag[i] == f && block_tag[i] == b &&
          (match < 0 || age[i] < age[match]))
        match = i;
    if (cmd == CMD_LOOKUP) begin
      if (match >= 0) begin
        r.hit   = 1'b1;
        r.frame = match[FRAME_OUT_W-1:0];
        promote(match);
      end else begin
        for (int i = FRAMES - 1; i >= 0; i--)
          if (age[i] == FRAMES - 1) victim = i;
        if (frame_used[victim]) begin
          r.write_back = 1'b1;
          r.old_file   = file_tag[victim];
          r.old_block  = block_tag[victim];
        end
        frame_used[victim] = 1'b1;
        file_tag[victim]   = f;
        block_tag[victim]  = b;
        r.frame            = victim[FRAME_OUT_W-1:0];
        promote(victim);
      end
    end else if (match >= 0) begin
      // emptied frame drops to least recent
      frame_used[match] = 1'b0;
      was = age[match];
      for (int i = 0; i < FRAMES; i++)
        if (age[i] > was) age[i]--;
      age[match] = FRAMES - 1;
      r.hit      = 1'b1;
      r.removed  = 1'b1;
      r.frame    = match[FRAME_OUT_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      replies_due.delete();
      for (int i = 0; i < FRAMES; i++) begin
        frame_used[i] = 1'b0;
        file_tag[i]   = '0;
        block_tag[i]  = '0;
        age[i]        = i;
      end
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        replies_seen++;
        got = m_tdata_i[OUT_DATA_W-2:0];
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("reply %h with no request outstanding", m_tdata_i));
        end else begin
          want = replies_due.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
          if (got.frame !== want.frame)
            report_mismatch($sformatf("frame %0d, want %0d", got.frame, want.frame));
          if (got.write_back !== want.write_back)
            report_mismatch($sformatf("write_back %b, want %b",
                                      got.write_back, want.write_back));
          if (got.old_file !== want.old_file)
            report_mismatch($sformatf("old_file_num %h, want %h",
                                      got.old_file, want.old_file));
          if (got.old_block !== want.old_block)
            report_mismatch($sformatf("old_block_num %h, want %h",
                                      got.old_block, want.old_block));
          if (got.removed !== want.removed)
            report_mismatch($sformatf("removed %b, want %b", got.removed, want.removed));
        end
        if (m_tdata_i[OUT_DATA_W-1] !== 1'b0)
          report_mismatch("padding bit not zero");
      end
      if (s_tvalid_i && s_tready_i)
        replies_due.push_back(apply_request(s_tuser_i, s_tdata_i[FILE_W-1:0],
                                            s_tdata_i[FILE_W +: BLOCK_W]));
      pending_o <= replies_due.size();
    end
    errors_o <= mismatches;
  end

endmodule

FILE: tb/lru_buffer_frame_manager_test.sv
// ----------------------------------------------------------------------------
// lru_buffer_frame_manager_test
// Drives lookups and deletes into the frame manager. The directed part covers
// the tag extremes, hits, misses into empty and occupied frames, and deletes
// with and without a match. The random part draws tags from a small working
// set, so hits, evictions and write-backs stay common. Both sides stall at
// random. The checker predicts every reply and counts mismatches.
// ----------------------------------------------------------------------------
module lru_buffer_frame_manager_test;
  import lbfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAMES       = 16;
  localparam int unsigned RANDOM_REQS  = 700;
  localparam int unsigned POOL_TAGS    = 24;
  localparam int unsigned SETTLE_TICKS = 4 * (FRAMES + 3);
  localparam int unsigned LONG_HOLD    = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // file_num, block_num
  logic                  s_tuser = 1'b0; // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    pending;
  int                    errors;

  // stretches where a side never idles
  logic sender_burst   = 1'b0;
  logic receiver_burst = 1'b0;
  int   replies_taken  = 0;

  logic [FILE_W-1:0]  pool_file  [POOL_TAGS];
  logic [BLOCK_W-1:0] pool_block [POOL_TAGS];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lru_buffer_frame_manager #(.FRAMES(FRAMES)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  lru_buffer_frame_manager_checker #(.FRAMES(FRAMES)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // Offer one request after a random gap and hold it until it is taken.
  task automatic send_request(input logic cmd, input logic [FILE_W-1:0] f,
                              input logic [BLOCK_W-1:0] b);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, f};
    s_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait for every outstanding reply.
  task automatic wait_drained;
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Reply side: random stall per reply, two long hold-offs to back the block up.
  initial begin : reply_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      replies_taken++;
      if (replies_taken == 150 || replies_taken == 450) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
    end
  end

  initial begin : request_source
    int unsigned        pick;
    int unsigned        pool_used;
    logic               cmd;
    logic [FILE_W-1:0]  f;
    logic [BLOCK_W-1:0] b;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, hit, partial tag match, delete hit and miss,
    // a miss into the frame just emptied, then enough new tags to evict.
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_LOOKUP, '1, '1);
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_LOOKUP, '1, '0);
    send_request(CMD_LOOKUP, '0, '1);
    send_request(CMD_DELETE, '1, '1);
    send_request(CMD_DELETE, '1, '1);
    send_request(CMD_LOOKUP, 16'h1234, 32'h0000_0005);
    for (int i = 0; i < 17; i++)
      send_request(CMD_LOOKUP, FILE_W'(16'h8000 | i), BLOCK_W'(~i));
    wait_drained();

    // Random: working set of tags so the pool keeps hitting and evicting.
    for (int i = 0; i < POOL_TAGS; i++) begin
      pool_file[i]  = FILE_W'($urandom);
      pool_block[i] = BLOCK_W'($urandom);
    end
    pool_used = POOL_TAGS;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 50 == 0) begin
        pool_used      = $urandom_range(4, POOL_TAGS);
        sender_burst   = ($urandom_range(0, 3) == 0);
        receiver_burst = ($urandom_range(0, 3) == 0);
      end
      if (n == 350)
        wait_drained();
      if ($urandom_range(0, 19) == 0) begin
        pick             = $urandom_range(0, POOL_TAGS - 1);
        pool_file[pick]  = FILE_W'($urandom);
        pool_block[pick] = BLOCK_W'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        f = FILE_W'($urandom);
        b = BLOCK_W'($urandom);
      end else if (pick < 11) begin
        f = $urandom_range(0, 1) ? '1 : '0;
        b = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        pick = $urandom_range(0, pool_used - 1);
        f    = pool_file[pick];
        b    = pool_block[pick];
      end
      cmd = ($urandom_range(0, 99) < 20) ? CMD_DELETE : CMD_LOOKUP;
      send_request(cmd, f, b);
    end
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
